@@ hw/rtl/tflg_pkg.sv @@
// ----------------------------------------------------------------------------
// tflg_pkg: shared types and constants of the throughput frequency lock governor
// Widths, register indexes, action codes, sequencer states and config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tflg_pkg;

  // Level table size and the clamp applied to level_count
  localparam int unsigned MAX_LEVELS  = 4;
  localparam int unsigned LIMIT_REGS  = 4;
  localparam int unsigned LEVELS_CAP  = (MAX_LEVELS < LIMIT_REGS) ? MAX_LEVELS : LIMIT_REGS;
  localparam int unsigned LIMIT_IDX_W = (LIMIT_REGS > 1) ? $clog2(LIMIT_REGS) : 1;

  // Field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned BYTE_W   = 16;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] LEVELS_CAP_L = LEVEL_W'(LEVELS_CAP);

  // Divider: dividend is byte total times eight
  localparam int unsigned BIT_SHIFT  = 3;
  localparam int unsigned DIVIDEND_W = DATA_W + BIT_SHIFT;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Reset values
  localparam logic [DATA_W-1:0] TRIGGER_RESET = DATA_W'(655360);
  localparam logic [HOLD_W-1:0] HOLD_RESET    = HOLD_W'(1000);

  // Register indexes
  localparam int unsigned REG_TRIGGER     = 0;
  localparam int unsigned REG_LEVEL_COUNT = 1;
  localparam int unsigned REG_LIMIT_BASE  = 2;
  localparam int unsigned REG_HOLD        = REG_LIMIT_BASE + LIMIT_REGS;

  // Result action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_RAISE   = 2'd0,
    ACT_LOWER   = 2'd1,
    ACT_RESTORE = 2'd2
  } action_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // Configuration bundle seen by the sequencer
  typedef struct packed {
    logic [DATA_W-1:0]                  trigger_bytes;
    logic [LEVEL_W-1:0]                 levels_used;
    logic [LIMIT_REGS-1:0][DATA_W-1:0]  speed_limit;
    logic [HOLD_W-1:0]                  hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/throughput_frequency_lock_governor.sv @@
// ----------------------------------------------------------------------------
// throughput_frequency_lock_governor: throughput driven frequency lock
// Accumulates packet bytes, measures kbit/s on trigger and requests lock levels.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in        input      in_valid_i/in_ready_o   kind_i, byte_count_i
//  out       output     out_valid_o/out_ready_i action_o, level_o, speed_kbps_o
//  cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
//  A packet that does not measure, or a tick, goes from exec to idle; a
//  restore tick goes on to emit. A measuring packet runs 35 divider steps,
//  scans the limits it exceeds, then decides and, on a result, emits.
//  One item is in work at a time; in_ready_o is high only in idle.
//  A result waits in the output register while the next item is accepted;
//  a new result waits in the emit state until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module throughput_frequency_lock_governor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [tflg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tflg_pkg::DATA_W-1:0]     cfg_data_i,
  // input items
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            kind_i,
  input  wire logic [tflg_pkg::BYTE_W-1:0]     byte_count_i,
  // result items
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [tflg_pkg::ACTION_W-1:0]        action_o,
  output logic [tflg_pkg::LEVEL_W-1:0]         level_o,
  output logic [tflg_pkg::DATA_W-1:0]          speed_kbps_o
);

  localparam int unsigned DatW = tflg_pkg::DATA_W;
  localparam int unsigned LvlW = tflg_pkg::LEVEL_W;
  localparam int unsigned HldW = tflg_pkg::HOLD_W;
  localparam int unsigned BytW = tflg_pkg::BYTE_W;
  localparam int unsigned IdxW = tflg_pkg::LIMIT_IDX_W;

  tflg_pkg::cfg_t   cfg;
  tflg_pkg::state_e state_q, state_d;

  // Governor state
  logic [DatW-1:0] total_q, total_d;
  logic [DatW-1:0] elapsed_q, elapsed_d;
  logic            lock_q, lock_d;
  logic [LvlW-1:0] cur_level_q, cur_level_d;
  logic [HldW-1:0] hold_q, hold_d;
  logic [DatW-1:0] speed_q, speed_d;
  logic [LvlW-1:0] scan_q, scan_d;

  // Item and pending result
  logic               kind_q;
  logic [BytW-1:0]    bytes_q;
  tflg_pkg::action_e  pend_action_q, pend_action_d;
  logic [LvlW-1:0]    pend_level_q, pend_level_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [tflg_pkg::ACTION_W-1:0] action_q;
  logic [LvlW-1:0]              level_q;
  logic [DatW-1:0]              speed_out_q;

  // Divider hookup
  logic                              div_start;
  logic                              div_done;
  logic [tflg_pkg::DIVIDEND_W-1:0]   div_quo;
  logic [DatW:0]                     sum_w;
  logic [DatW-1:0]                   sum_sat;
  logic                              scan_more;
  logic                              out_free;

  tflg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tflg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_sat, tflg_pkg::BIT_SHIFT'(0)}),
    .divisor_i  (elapsed_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturating byte add and level scan compare
  always_comb begin
    sum_w     = {1'b0, total_q} + {{(DatW + 1 - BytW){1'b0}}, bytes_q};
    sum_sat   = sum_w[DatW] ? '1 : sum_w[DatW-1:0];
    scan_more = (scan_q < cfg.levels_used) &&
                (speed_q > cfg.speed_limit[scan_q[IdxW-1:0]]);
    out_free  = !out_valid_q || out_ready_i;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tflg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tflg_pkg::ST_EXEC;
      end
      tflg_pkg::ST_EXEC: begin
        if (kind_q) begin
          if (!lock_q) state_d = tflg_pkg::ST_IDLE;
          else if (hold_q <= HldW'(1)) state_d = tflg_pkg::ST_EMIT;
          else state_d = tflg_pkg::ST_IDLE;
        end else if (sum_sat <= cfg.trigger_bytes || elapsed_q == '0) begin
          state_d = tflg_pkg::ST_IDLE;
        end else begin
          state_d = tflg_pkg::ST_DIV;
        end
      end
      tflg_pkg::ST_DIV: begin
        if (div_done) state_d = tflg_pkg::ST_SCAN;
      end
      tflg_pkg::ST_SCAN: begin
        if (!scan_more) state_d = tflg_pkg::ST_DECIDE;
      end
      tflg_pkg::ST_DECIDE: begin
        if (scan_q == '0) state_d = tflg_pkg::ST_IDLE;
        else if (!lock_q || scan_q != cur_level_q) state_d = tflg_pkg::ST_EMIT;
        else state_d = tflg_pkg::ST_IDLE;
      end
      tflg_pkg::ST_EMIT: begin
        if (out_free) state_d = tflg_pkg::ST_IDLE;
      end
      default: state_d = tflg_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    total_d       = total_q;
    elapsed_d     = elapsed_q;
    lock_d        = lock_q;
    cur_level_d   = cur_level_q;
    hold_d        = hold_q;
    speed_d       = speed_q;
    scan_d        = scan_q;
    pend_action_d = pend_action_q;
    pend_level_d  = pend_level_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    div_start     = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      tflg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      tflg_pkg::ST_EXEC: begin
        if (kind_q) begin
          // advance elapsed time and count down the hold
          if (elapsed_q != '1) elapsed_d = elapsed_q + 1'b1;
          if (lock_q) begin
            if (hold_q <= HldW'(1)) begin
              hold_d        = '0;
              lock_d        = 1'b0;
              pend_action_d = tflg_pkg::ACT_RESTORE;
              pend_level_d  = '0;
            end else begin
              hold_d = hold_q - 1'b1;
            end
          end
        end else if (sum_sat <= cfg.trigger_bytes) begin
          total_d = sum_sat;
        end else begin
          // restart the window; measure only when time has passed
          total_d   = '0;
          elapsed_d = '0;
          div_start = (elapsed_q != '0);
        end
      end
      tflg_pkg::ST_DIV: begin
        if (div_done) begin
          speed_d = (div_quo[tflg_pkg::DIVIDEND_W-1:DatW] != '0) ? '1 : div_quo[DatW-1:0];
          scan_d  = '0;
        end
      end
      tflg_pkg::ST_SCAN: begin
        if (scan_more) scan_d = scan_q + 1'b1;
      end
      tflg_pkg::ST_DECIDE: begin
        if (scan_q != '0) begin
          hold_d       = cfg.hold_ms;
          lock_d       = 1'b1;
          cur_level_d  = scan_q;
          pend_level_d = scan_q;
          if (lock_q && scan_q < cur_level_q) pend_action_d = tflg_pkg::ACT_LOWER;
          else pend_action_d = tflg_pkg::ACT_RAISE;
        end
      end
      tflg_pkg::ST_EMIT: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Control and governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tflg_pkg::ST_IDLE;
      total_q     <= '0;
      elapsed_q   <= '0;
      lock_q      <= 1'b0;
      cur_level_q <= '0;
      hold_q      <= '0;
      speed_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      elapsed_q   <= elapsed_d;
      lock_q      <= lock_d;
      cur_level_q <= cur_level_d;
      hold_q      <= hold_d;
      speed_q     <= speed_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item on transfer and load the result on emit
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      bytes_q <= byte_count_i;
    end
    pend_action_q <= pend_action_d;
    pend_level_q  <= pend_level_d;
    if (state_q == tflg_pkg::ST_EMIT && out_free) begin
      action_q    <= pend_action_q;
      level_q     <= pend_level_q;
      speed_out_q <= speed_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign level_o      = level_q;
  assign speed_kbps_o = speed_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/tflg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tflg_cfg_regs: configuration register file
// Takes plain writes by index and presents the clamped level count.
// ----------------------------------------------------------------------------
`default_nettype none

module tflg_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tflg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tflg_pkg::DATA_W-1:0]     cfg_data_i,
  output tflg_pkg::cfg_t                       cfg_o
);

  logic [tflg_pkg::DATA_W-1:0]                        trigger_q;
  logic [tflg_pkg::LEVEL_W-1:0]                       level_count_q;
  logic [tflg_pkg::LIMIT_REGS-1:0][tflg_pkg::DATA_W-1:0] limit_q;
  logic [tflg_pkg::HOLD_W-1:0]                        hold_q;

  // Write the addressed register; unused indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q     <= tflg_pkg::TRIGGER_RESET;
      level_count_q <= '0;
      limit_q       <= '0;
      hold_q        <= tflg_pkg::HOLD_RESET;
    end else if (cfg_we_i) begin
      if (32'(cfg_index_i) == tflg_pkg::REG_TRIGGER) begin
        trigger_q <= cfg_data_i;
      end
      if (32'(cfg_index_i) == tflg_pkg::REG_LEVEL_COUNT) begin
        level_count_q <= cfg_data_i[tflg_pkg::LEVEL_W-1:0];
      end
      for (int i = 0; i < tflg_pkg::LIMIT_REGS; i++) begin
        if (32'(cfg_index_i) == tflg_pkg::REG_LIMIT_BASE + i) begin
          limit_q[i] <= cfg_data_i;
        end
      end
      if (32'(cfg_index_i) == tflg_pkg::REG_HOLD) begin
        hold_q <= cfg_data_i[tflg_pkg::HOLD_W-1:0];
      end
    end
  end

  // Clamp the level count to the table size
  always_comb begin
    cfg_o.trigger_bytes = trigger_q;
    cfg_o.levels_used   = (level_count_q > tflg_pkg::LEVELS_CAP_L) ?
                          tflg_pkg::LEVELS_CAP_L : level_count_q;
    cfg_o.speed_limit   = limit_q;
    cfg_o.hold_ms       = hold_q;
  end

endmodule

`default_nettype wire

@@ hw/rtl/tflg_divider.sv @@
// ----------------------------------------------------------------------------
// tflg_divider: iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module tflg_divider (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [tflg_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  wire logic [tflg_pkg::DATA_W-1:0]      divisor_i,
  output logic                                  done_o,
  output logic [tflg_pkg::DIVIDEND_W-1:0]       quotient_o
);

  localparam int unsigned DvdW = tflg_pkg::DIVIDEND_W;
  localparam int unsigned DatW = tflg_pkg::DATA_W;
  localparam int unsigned CntW = tflg_pkg::DIV_CNT_W;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DatW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DatW-1:0] dsr_q, dsr_d;
  logic [DatW+1:0] trial;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    trial  = {1'b0, rem_q, quo_q[DvdW-1]} - {2'b00, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[DatW+1]) begin
        rem_d = {rem_q[DatW-2:0], quo_q[DvdW-1]};
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end else begin
        rem_d = trial[DatW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
